// File: design/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg: shared definitions for the damage rectangle coalescer
// Register indexes and reset values, port widths, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

   // Fixed port widths.
   localparam int POS_BITS      = 14;
   localparam int SIZE_BITS     = 15;
   localparam int EDGE_BITS     = 15;
   localparam int MARGIN_BITS   = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 15;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GROW_MARGIN    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MONITOR_ENABLE = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 15'd1920;
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 15'd1080;
   localparam logic [MARGIN_BITS-1:0]   GROW_MARGIN_RESET   = 8'd30;

   // Input action codes.
   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// File: design/damage_rect_coalescer_unit.sv
// ----------------------------------------------------------------------------
// damage_rect_coalescer_unit: coalesces screen damage rectangles into tiles
// An add is accepted, then compared with the stored tiles in order until one
//   overlaps or the last is reached; a zero-size add is dropped when accepted.
// A flush emits one tile word per cycle while rsp_ready is high; an empty or
//   disabled flush answers with a single invalid word.
// The tile loop runs on one shared compare and union unit fed by a tile
//   memory with one write port and one read port with registered read data.
// Reset (synchronous, active high) empties the table, clears the overflow flag
//   and the handshakes and restores the register defaults; tile memory
//   contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module damage_rect_coalescer_unit
   import drc_pkg::*;
#(
   parameter int MAX_TILES  = 16,
   parameter int COORD_BITS = 14
) (
   input  wire                       clock,
   input  wire                       reset,

   input  wire                       csr_wen,
   input  wire [CSR_IDX_BITS-1:0]    csr_index,
   input  wire [CSR_DATA_BITS-1:0]   csr_wdata,

   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire                       req_action,
   input  wire [POS_BITS-1:0]        req_rect_x,
   input  wire [POS_BITS-1:0]        req_rect_y,
   input  wire [SIZE_BITS-1:0]       req_rect_w,
   input  wire [SIZE_BITS-1:0]       req_rect_h,

   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [EDGE_BITS-1:0]      rsp_tile_left,
   output logic [EDGE_BITS-1:0]      rsp_tile_top,
   output logic [EDGE_BITS-1:0]      rsp_tile_right,
   output logic [EDGE_BITS-1:0]      rsp_tile_bottom,
   output logic                      rsp_tile_valid,
   output logic                      rsp_table_overflowed,
   output logic                      rsp_last_tile
);

   // Index into the tile memory, and a count that can also hold MAX_TILES.
   localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CW = $clog2(MAX_TILES + 1);
   // Width for the rectangle end sums; x + w - 1 stays below 2^16.
   localparam int SUMW = (COORD_BITS > 16) ? COORD_BITS : 16;
   // Width for grown edges: a stored edge plus the margin, or a screen size.
   localparam int GW = (COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16;
   localparam logic [SUMW-1:0] CMAX = SUMW'((32'd1 << COORD_BITS) - 32'd1);
   localparam logic [CW-1:0]   TILES_FULL = CW'(MAX_TILES);
   localparam logic [IW-1:0]   LAST_SLOT  = IW'(MAX_TILES - 1);

   typedef struct packed {
      logic [COORD_BITS-1:0] l;
      logic [COORD_BITS-1:0] t;
      logic [COORD_BITS-1:0] r;
      logic [COORD_BITS-1:0] b;
   } tile_type;

   // -------------------------------------------------------------------------
   // Configuration registers.
   // -------------------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0] screen_width_ff;
   logic [CSR_DATA_BITS-1:0] screen_height_ff;
   logic [MARGIN_BITS-1:0]   grow_margin_ff;
   logic                     monitor_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff   <= SCREEN_WIDTH_RESET;
         screen_height_ff  <= SCREEN_HEIGHT_RESET;
         grow_margin_ff    <= GROW_MARGIN_RESET;
         monitor_enable_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_wdata;
            CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_wdata;
            CSR_GROW_MARGIN:    grow_margin_ff    <= csr_wdata[MARGIN_BITS-1:0];
            CSR_MONITOR_ENABLE: monitor_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // State.
   // -------------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   tile_type         new_ff, new_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [EDGE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic [EDGE_BITS-1:0] rsp_top_ff, rsp_top_in;
   logic [EDGE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic [EDGE_BITS-1:0] rsp_bottom_ff, rsp_bottom_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_last_ff, rsp_last_in;

   // Tile memory: one write port, one read port with registered data.
   tile_type         tile_mem [MAX_TILES];
   tile_type         rd_ff;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   tile_type         wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tile_mem[wr_addr] <= wr_data;
      end
      rd_ff <= tile_mem[rd_addr];
   end

   // -------------------------------------------------------------------------
   // Input decode: saturate the incoming rectangle to the coordinate range.
   // -------------------------------------------------------------------------
   logic             accept;
   logic             zero_size;
   logic [SUMW-1:0]  x_ext, y_ext, x_end, y_end;

   assign accept    = req_valid && req_ready;
   assign zero_size = (req_rect_w == '0) || (req_rect_h == '0);
   assign x_ext     = SUMW'(req_rect_x);
   assign y_ext     = SUMW'(req_rect_y);
   assign x_end     = x_ext + SUMW'(req_rect_w) - SUMW'(1);
   assign y_end     = y_ext + SUMW'(req_rect_h) - SUMW'(1);

   always_comb begin
      new_in.l = (x_ext > CMAX) ? CMAX[COORD_BITS-1:0] : x_ext[COORD_BITS-1:0];
      new_in.t = (y_ext > CMAX) ? CMAX[COORD_BITS-1:0] : y_ext[COORD_BITS-1:0];
      new_in.r = (x_end > CMAX) ? CMAX[COORD_BITS-1:0] : x_end[COORD_BITS-1:0];
      new_in.b = (y_end > CMAX) ? CMAX[COORD_BITS-1:0] : y_end[COORD_BITS-1:0];
   end

   // -------------------------------------------------------------------------
   // Shared compare and union unit, working on the tile just read.
   // -------------------------------------------------------------------------
   logic     overlap, hit, at_end, table_full, out_free;
   tile_type merged;

   assign overlap = (new_ff.l <= rd_ff.r) && (rd_ff.l <= new_ff.r) &&
                    (new_ff.t <= rd_ff.b) && (rd_ff.t <= new_ff.b);
   assign hit        = (count_ff != '0) && overlap;
   assign at_end     = (count_ff == '0) || (CW'(idx_ff) == count_ff - CW'(1));
   assign table_full = (count_ff == TILES_FULL);
   // The output register can take a word when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      merged.l = (rd_ff.l < new_ff.l) ? rd_ff.l : new_ff.l;
      merged.t = (rd_ff.t < new_ff.t) ? rd_ff.t : new_ff.t;
      merged.r = (rd_ff.r > new_ff.r) ? rd_ff.r : new_ff.r;
      merged.b = (rd_ff.b > new_ff.b) ? rd_ff.b : new_ff.b;
   end

   // Grown and clamped edges of the tile just read, for a flush.
   logic [GW-1:0] margin_ext, rd_l, rd_t, r_sum, b_sum, sw_ext, sh_ext;
   logic [GW-1:0] grown_l, grown_t, grown_r, grown_b;

   assign margin_ext = GW'(grow_margin_ff);
   assign rd_l       = GW'(rd_ff.l);
   assign rd_t       = GW'(rd_ff.t);
   assign r_sum      = GW'(rd_ff.r) + margin_ext;
   assign b_sum      = GW'(rd_ff.b) + margin_ext;
   assign sw_ext     = GW'(screen_width_ff);
   assign sh_ext     = GW'(screen_height_ff);
   assign grown_l    = (rd_l > margin_ext) ? rd_l - margin_ext : '0;
   assign grown_t    = (rd_t > margin_ext) ? rd_t - margin_ext : '0;
   assign grown_r    = (r_sum < sw_ext) ? r_sum : sw_ext;
   assign grown_b    = (b_sum < sh_ext) ? b_sum : sh_ext;

   // -------------------------------------------------------------------------
   // Sequencer: next state.
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_ADD) begin
                  if (!zero_size) begin
                     state_in = ST_SCAN;
                  end
               end else if (monitor_enable_ff && (count_ff != '0)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (hit || at_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && at_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer: datapath controls and register next values.
   // -------------------------------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      idx_in        = idx_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = merged;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_left_in   = rsp_left_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // A flush may need the output register, so wait until it is free.
            req_ready = out_free;
            idx_in    = '0;
            if (accept && (req_action == ACTION_FLUSH) &&
                !(monitor_enable_ff && (count_ff != '0))) begin
               // Empty or disabled flush: one invalid word, tiles untouched.
               rsp_valid_in  = 1'b1;
               rsp_left_in   = '0;
               rsp_top_in    = '0;
               rsp_right_in  = '0;
               rsp_bottom_in = '0;
               rsp_tvalid_in = 1'b0;
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = 1'b1;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               wr_en = 1'b1;
            end else if (at_end) begin
               wr_en = 1'b1;
               if (!table_full) begin
                  // Append as a new tile.
                  wr_addr  = count_ff[IW-1:0];
                  wr_data  = new_ff;
                  count_in = count_ff + CW'(1);
               end else begin
                  // Full table: the last tile (just read) absorbs the rectangle.
                  wr_addr = LAST_SLOT;
                  ovf_in  = 1'b1;
               end
            end else begin
               idx_in  = idx_ff + IW'(1);
               rd_addr = idx_ff + IW'(1);
            end
         end
         ST_EMIT: begin
            rd_addr = idx_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = grown_l[EDGE_BITS-1:0];
               rsp_top_in    = grown_t[EDGE_BITS-1:0];
               rsp_right_in  = grown_r[EDGE_BITS-1:0];
               rsp_bottom_in = grown_b[EDGE_BITS-1:0];
               rsp_tvalid_in = 1'b1;
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = at_end;
               if (at_end) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  rd_addr  = '0;
               end else begin
                  idx_in  = idx_ff + IW'(1);
                  rd_addr = idx_ff + IW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         new_ff <= new_in;
      end
      rsp_left_ff   <= rsp_left_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tile_left        = rsp_left_ff;
   assign rsp_tile_top         = rsp_top_ff;
   assign rsp_tile_right       = rsp_right_ff;
   assign rsp_tile_bottom      = rsp_bottom_ff;
   assign rsp_tile_valid       = rsp_tvalid_ff;
   assign rsp_table_overflowed = rsp_ovf_ff;
   assign rsp_last_tile        = rsp_last_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   // The table never holds more tiles than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= TILES_FULL)
      else $error("tile count beyond table size");

   // Overflow can only have been recorded while the table is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> table_full)
      else $error("overflow flag set with table not full");

   // The scan and emit index always points at a stored tile.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN || state_ff == ST_EMIT) && (count_ff != '0))
         |-> (CW'(idx_ff) < count_ff))
      else $error("tile index beyond stored tiles");

   // Emitting the final tile of a flush empties the table.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && at_end)
         |=> (count_ff == '0 && !ovf_ff && rsp_valid && rsp_last_tile))
      else $error("flush did not empty the table");

endmodule

`default_nettype wire

// File: tb/damage_rect_coalescer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// damage_rect_coalescer_unit_test: self-checking bench for the rectangle coalescer
// A short scripted run covers the drop, clamp, overflow and empty-flush cases,
// then random damage traffic runs under several register settings and idling
// patterns. Every result word is checked against a behavioral tile table or a hand-written word.
// ----------------------------------------------------------------------------

module damage_rect_coalescer_unit_test;
   import drc_pkg::*;

   localparam int TILE_SLOTS    = 16;
   localparam int COORD_MAX     = 16383;
   localparam int SETTLE_CYCLES = 40;    // longest add scan plus margin
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off under pressure
   localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake
   localparam int PHASE_ITEMS   = 65;
   localparam int PRINT_LIMIT   = 200;

   // One stored tile, inclusive edges at coordinate width.
   typedef struct packed {
      logic [POS_BITS-1:0] l;
      logic [POS_BITS-1:0] t;
      logic [POS_BITS-1:0] r;
      logic [POS_BITS-1:0] b;
   } tile_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [EDGE_BITS-1:0] left;
      logic [EDGE_BITS-1:0] top;
      logic [EDGE_BITS-1:0] right;
      logic [EDGE_BITS-1:0] bottom;
      logic                 valid;
      logic                 overflowed;
      logic                 last;
   } tile_word_type;

   // A full set of register values, always written together.
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] width;
      logic [CSR_DATA_BITS-1:0] height;
      logic [MARGIN_BITS-1:0]   margin;
      logic                     enable;
   } csr_set_type;

   // One row of the scripted part. When typed is set, want holds the result
   // word written out by hand; otherwise the tile table supplies it.
   typedef struct packed {
      logic                 reconfig;
      csr_set_type          regs;
      logic                 action;
      logic [POS_BITS-1:0]  x;
      logic [POS_BITS-1:0]  y;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      logic                 typed;
      tile_word_type        want;
   } stim_row_type;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_type;

   localparam tile_word_type NO_WORD     = '0;
   localparam tile_word_type EMPTY_FLUSH = '{left: '0, top: '0, right: '0, bottom: '0,
                                             valid: 1'b0, overflowed: 1'b0, last: 1'b1};
   localparam csr_set_type   ENABLE_ONLY = '{width: 15'd1920, height: 15'd1080,
                                             margin: 8'd30, enable: 1'b1};
   localparam csr_set_type   FULL_SCREEN = '{width: 15'd16384, height: 15'd16384,
                                             margin: 8'd255, enable: 1'b1};

   // Clock, reset and all block inputs start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_wen   = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic                 req_valid  = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACTION_ADD;
   logic [POS_BITS-1:0]  req_rect_x = '0;
   logic [POS_BITS-1:0]  req_rect_y = '0;
   logic [SIZE_BITS-1:0] req_rect_w = '0;
   logic [SIZE_BITS-1:0] req_rect_h = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [EDGE_BITS-1:0] rsp_tile_left;
   logic [EDGE_BITS-1:0] rsp_tile_top;
   logic [EDGE_BITS-1:0] rsp_tile_right;
   logic [EDGE_BITS-1:0] rsp_tile_bottom;
   logic                 rsp_tile_valid;
   logic                 rsp_table_overflowed;
   logic                 rsp_last_tile;

   // Behavioral copy of the block: registers, tile table and overflow flag.
   logic [CSR_DATA_BITS-1:0] cfg_width  = SCREEN_WIDTH_RESET;
   logic [CSR_DATA_BITS-1:0] cfg_height = SCREEN_HEIGHT_RESET;
   logic [MARGIN_BITS-1:0]   cfg_margin = GROW_MARGIN_RESET;
   logic                     cfg_enable = 1'b0;
   tile_type                 tiles [TILE_SLOTS];
   int                       tile_total = 0;
   logic                     overflowed = 1'b0;

   tile_word_type tile_words[$];    // result words still to come, oldest first
   tile_word_type head_word;
   stim_row_type  script[$];
   idle_mode_type idle_mode   = IDLE_NONE;
   int            error_count = 0;
   int            quiet_cycles = 0;

   damage_rect_coalescer_unit uut (
      .clock                (clock),
      .reset                (reset),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_rect_x           (req_rect_x),
      .req_rect_y           (req_rect_y),
      .req_rect_w           (req_rect_w),
      .req_rect_h           (req_rect_h),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_tile_left        (rsp_tile_left),
      .rsp_tile_top         (rsp_tile_top),
      .rsp_tile_right       (rsp_tile_right),
      .rsp_tile_bottom      (rsp_tile_bottom),
      .rsp_tile_valid       (rsp_tile_valid),
      .rsp_table_overflowed (rsp_table_overflowed),
      .rsp_last_tile        (rsp_last_tile)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Tile table prediction
   // ------------------------------------------------------------------------

   // A damage rectangle is clipped to the coordinate range, then merged into
   // the first tile it touches (edges count as touching). With no touching
   // tile it takes a new slot, or, once all slots are used, is forced into
   // the last slot and the overflow flag goes up.
   function automatic void merge_damage(input logic [POS_BITS-1:0] x, y,
                                        input logic [SIZE_BITS-1:0] w, h);
      tile_type rect;
      int       far_x;
      int       far_y;
      int       hit;
      if (w == 0 || h == 0)
         return;
      far_x  = x + w - 1;
      far_y  = y + h - 1;
      rect.l = x;
      rect.t = y;
      rect.r = (far_x > COORD_MAX) ? POS_BITS'(COORD_MAX) : POS_BITS'(far_x);
      rect.b = (far_y > COORD_MAX) ? POS_BITS'(COORD_MAX) : POS_BITS'(far_y);
      hit = -1;
      for (int i = 0; i < tile_total; i++) begin
         if (hit < 0 && rect.l <= tiles[i].r && tiles[i].l <= rect.r &&
             rect.t <= tiles[i].b && tiles[i].t <= rect.b)
            hit = i;
      end
      if (hit < 0) begin
         if (tile_total < TILE_SLOTS) begin
            tiles[tile_total] = rect;
            tile_total++;
            return;
         end
         hit = TILE_SLOTS - 1;
         overflowed = 1'b1;
      end
      if (rect.l < tiles[hit].l) tiles[hit].l = rect.l;
      if (rect.t < tiles[hit].t) tiles[hit].t = rect.t;
      if (rect.r > tiles[hit].r) tiles[hit].r = rect.r;
      if (rect.b > tiles[hit].b) tiles[hit].b = rect.b;
   endfunction

   // A flush either answers with one empty word (monitoring off or nothing
   // stored; the table is then left alone) or emits every tile grown by the
   // margin, floored at 0 and capped at the screen size, and empties the
   // table. No ordering check is made between right and left: a small screen
   // may legally give right below left.
   function automatic void flush_tiles();
      tile_word_type word;
      int            grown;
      if (!cfg_enable || tile_total == 0) begin
         word            = EMPTY_FLUSH;
         word.overflowed = overflowed;
         tile_words.push_back(word);
         return;
      end
      for (int i = 0; i < tile_total; i++) begin
         word.left   = (tiles[i].l > cfg_margin) ? tiles[i].l - cfg_margin : '0;
         word.top    = (tiles[i].t > cfg_margin) ? tiles[i].t - cfg_margin : '0;
         grown       = tiles[i].r + cfg_margin;
         word.right  = (grown > cfg_width) ? cfg_width : EDGE_BITS'(grown);
         grown       = tiles[i].b + cfg_margin;
         word.bottom = (grown > cfg_height) ? cfg_height : EDGE_BITS'(grown);
         word.valid      = 1'b1;
         word.overflowed = overflowed;
         word.last       = (i == tile_total - 1);
         tile_words.push_back(word);
      end
      tile_total = 0;
      overflowed = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void add_row(input logic reconfig, input csr_set_type regs,
                                   input logic action, input int x, y, w, h,
                                   input logic typed, input tile_word_type want);
      stim_row_type row;
      row.reconfig = reconfig;
      row.regs     = regs;
      row.action   = action;
      row.x        = POS_BITS'(x);
      row.y        = POS_BITS'(y);
      row.w        = SIZE_BITS'(w);
      row.h        = SIZE_BITS'(h);
      row.typed    = typed;
      row.want     = want;
      script.push_back(row);
   endfunction

   // Random damage traffic. Most adds land in a small cluster so that they
   // merge; a grid spread builds many separate tiles so the table fills up;
   // the rest are full-range, screen-corner and zero-size rectangles.
   function automatic void random_damage(input int flush_pct, output logic action,
                                         output logic [POS_BITS-1:0] x, y,
                                         output logic [SIZE_BITS-1:0] w, h);
      int pick;
      action = ($urandom_range(0, 99) < flush_pct) ? ACTION_FLUSH : ACTION_ADD;
      pick   = $urandom_range(0, 99);
      x = POS_BITS'($urandom);
      y = POS_BITS'($urandom);
      w = SIZE_BITS'($urandom_range(0, 16384));
      h = SIZE_BITS'($urandom_range(0, 16384));
      if (action == ACTION_FLUSH)
         return;
      if (pick < 55) begin
         x = POS_BITS'($urandom_range(0, 511));
         y = POS_BITS'($urandom_range(0, 511));
         w = SIZE_BITS'($urandom_range(1, 48));
         h = SIZE_BITS'($urandom_range(1, 48));
      end else if (pick < 75) begin
         x = POS_BITS'($urandom_range(0, 63) * 256);
         y = POS_BITS'($urandom_range(0, 63) * 256);
         w = SIZE_BITS'($urandom_range(1, 200));
         h = SIZE_BITS'($urandom_range(1, 200));
      end else if (pick < 85) begin
         // Full-range values, already drawn above.
      end else if (pick < 93) begin
         x = POS_BITS'($urandom_range(16380, COORD_MAX));
         y = POS_BITS'($urandom_range(16380, COORD_MAX));
         w = SIZE_BITS'($urandom_range(16380, 16384));
         h = SIZE_BITS'($urandom_range(16380, 16384));
      end else if ($urandom_range(0, 1) == 0) begin
         w = '0;
      end else begin
         h = '0;
      end
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SEND: return 56;
         IDLE_BOTH: return 21;
         default:   return 0;
      endcase
   endfunction

   // Offers one word and returns in the step of its acceptance, after the
   // tile table has taken it. All drives happen right after a rising edge.
   task automatic send_item(input logic action, input logic [POS_BITS-1:0] x, y,
                            input logic [SIZE_BITS-1:0] w, h);
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_rect_x <= x;
      req_rect_y <= y;
      req_rect_w <= w;
      req_rect_h <= h;
      do
         @(posedge clock);
      while (!(req_valid && req_ready === 1'b1));
      if (action == ACTION_ADD)
         merge_damage(x, y, w, h);
      else
         flush_tiles();
   endtask

   // Stops offering, waits for every outstanding word, then gives a trailing
   // add time to finish its scan, since an add produces no word of its own.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tile_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across back-to-back writes; the caller lowers it.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_SCREEN_WIDTH:   cfg_width  = value;
         CSR_SCREEN_HEIGHT:  cfg_height = value;
         CSR_GROW_MARGIN:    cfg_margin = value[MARGIN_BITS-1:0];
         CSR_MONITOR_ENABLE: cfg_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input csr_set_type regs);
      drain_results();
      write_reg(CSR_SCREEN_WIDTH, regs.width);
      write_reg(CSR_SCREEN_HEIGHT, regs.height);
      write_reg(CSR_GROW_MARGIN, CSR_DATA_BITS'(regs.margin));
      write_reg(CSR_MONITOR_ENABLE, CSR_DATA_BITS'(regs.enable));
      csr_wen <= 1'b0;
   endtask

   task automatic report_mismatch(input string field,
                                  input logic [EDGE_BITS-1:0] got, want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready pattern and word checking
   // ------------------------------------------------------------------------

   // Ready follows the idling pattern of the current phase. Under pressure
   // the receiver holds off for a long stretch, counted here, so the block
   // backs up and stalls its input; then it drains for a while.
   initial begin
      int hold_count;
      hold_count = 0;
      forever begin
         @(posedge clock);
         case (idle_mode)
            IDLE_RECV: rsp_ready <= ($urandom_range(0, 99) >= 56);
            IDLE_BOTH: rsp_ready <= ($urandom_range(0, 99) >= 21);
            IDLE_HOLD: begin
               rsp_ready  <= (hold_count >= HOLD_CYCLES);
               hold_count = (hold_count >= HOLD_CYCLES + 60) ? 0 : hold_count + 1;
            end
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // Each accepted word is compared field by field with the oldest one
   // still expected.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (tile_words.size() == 0) begin
            report_mismatch("unexpected word, tile_left", rsp_tile_left, '0);
         end else begin
            head_word = tile_words.pop_front();
            if (rsp_tile_left !== head_word.left)
               report_mismatch("tile_left", rsp_tile_left, head_word.left);
            if (rsp_tile_top !== head_word.top)
               report_mismatch("tile_top", rsp_tile_top, head_word.top);
            if (rsp_tile_right !== head_word.right)
               report_mismatch("tile_right", rsp_tile_right, head_word.right);
            if (rsp_tile_bottom !== head_word.bottom)
               report_mismatch("tile_bottom", rsp_tile_bottom, head_word.bottom);
            if (rsp_tile_valid !== head_word.valid)
               report_mismatch("tile_valid", rsp_tile_valid, head_word.valid);
            if (rsp_table_overflowed !== head_word.overflowed)
               report_mismatch("table_overflowed", rsp_table_overflowed,
                               head_word.overflowed);
            if (rsp_last_tile !== head_word.last)
               report_mismatch("last_tile", rsp_last_tile, head_word.last);
         end
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic                 action;
      logic [POS_BITS-1:0]  x;
      logic [POS_BITS-1:0]  y;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      csr_set_type          regs;
      int                   flush_pct;
      int                   useful;

      // Scripted part, under the register defaults first (monitoring off).
      // A flush of an empty table gives the empty word.
      add_row(1'b0, '0, ACTION_FLUSH, 0, 0, 0, 0, 1'b1, EMPTY_FLUSH);
      // Zero width, then zero height: both dropped.
      add_row(1'b0, '0, ACTION_ADD, 0, 0, 0, 5, 1'b0, NO_WORD);
      add_row(1'b0, '0, ACTION_ADD, 0, 0, 5, 0, 1'b0, NO_WORD);
      // Largest corner and size: the far edges saturate at the coordinate limit.
      add_row(1'b0, '0, ACTION_ADD, COORD_MAX, COORD_MAX, 16384, 16384, 1'b0, NO_WORD);
      // Monitoring off: empty word, and the tile stays stored.
      add_row(1'b0, '0, ACTION_FLUSH, 0, 0, 0, 0, 1'b1, EMPTY_FLUSH);
      // Monitoring on: the corner tile grows past the 1920x1080 screen, so the
      // far edges clamp below the near ones.
      add_row(1'b1, ENABLE_ONLY, ACTION_FLUSH, 0, 0, 0, 0, 1'b1,
              '{left: 15'd16353, top: 15'd16353, right: 15'd1920, bottom: 15'd1080,
                valid: 1'b1, overflowed: 1'b0, last: 1'b1});
      // The table is empty again after an enabled flush.
      add_row(1'b0, '0, ACTION_FLUSH, 0, 0, 0, 0, 1'b1, EMPTY_FLUSH);
      // Store separate small tiles in all but one slot, on the largest screen.
      for (int i = 0; i < TILE_SLOTS - 1; i++)
         add_row(i == 0, FULL_SCREEN, ACTION_ADD, 4 * i, 0, 2, 2, 1'b0, NO_WORD);
      // Touches the first two tiles on a shared edge: only the first grows.
      add_row(1'b0, '0, ACTION_ADD, 1, 1, 4, 1, 1'b0, NO_WORD);
      add_row(1'b0, '0, ACTION_ADD, COORD_MAX, COORD_MAX, 16384, 16384, 1'b0, NO_WORD);
      // The table is full: this one is forced into the last tile.
      add_row(1'b0, '0, ACTION_ADD, 100, 100, 1, 1, 1'b0, NO_WORD);
      add_row(1'b0, '0, ACTION_FLUSH, 0, 0, 0, 0, 1'b0, NO_WORD);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].reconfig)
            apply_config(script[i].regs);
         send_item(script[i].action, script[i].x, script[i].y, script[i].w, script[i].h);
         // Hand-written rows each answer with a single word.
         if (script[i].typed)
            tile_words[tile_words.size() - 1] = script[i].want;
      end

      // Random part: one register setting and one idling pattern per phase.
      // The monitoring-off phase lets tiles pile up so the next phase
      // flushes an overflowed table while the receiver backs the block up.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               regs = ENABLE_ONLY;
               idle_mode = IDLE_NONE;
               flush_pct = 12;
            end
            1: begin
               regs = '{width: CSR_DATA_BITS'($urandom_range(1, 16384)),
                        height: CSR_DATA_BITS'($urandom_range(1, 16384)),
                        margin: MARGIN_BITS'($urandom_range(0, 255)), enable: 1'b1};
               idle_mode = IDLE_SEND;
               flush_pct = 10;
            end
            2: begin
               regs = '{width: 15'd1, height: 15'd1, margin: 8'd0, enable: 1'b1};
               idle_mode = IDLE_RECV;
               flush_pct = 15;
            end
            3: begin
               regs = FULL_SCREEN;
               regs.enable = 1'b0;
               idle_mode = IDLE_BOTH;
               flush_pct = 10;
            end
            4: begin
               regs = '{width: 15'd640, height: 15'd480, margin: 8'd255, enable: 1'b1};
               idle_mode = IDLE_HOLD;
               flush_pct = 40;
            end
            default: begin
               regs = '{width: CSR_DATA_BITS'($urandom_range(1, 16384)),
                        height: CSR_DATA_BITS'($urandom_range(1, 16384)),
                        margin: MARGIN_BITS'($urandom_range(0, 255)), enable: 1'b1};
               idle_mode = IDLE_NONE;
               flush_pct = 5;
            end
         endcase
         apply_config(regs);
         useful = 0;
         // Zero-size adds are ignored by the block and do not count.
         while (useful < PHASE_ITEMS) begin
            random_damage(flush_pct, action, x, y, w, h);
            send_item(action, x, y, w, h);
            if (action == ACTION_FLUSH || (w != 0 && h != 0))
               useful++;
         end
      end

      drain_results();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
